### hdl/gcv_pkg.sv
package gcv_pkg;

  localparam int MaxColumnsDef = 256;
  localparam int MaxRowsDef    = 256;

  localparam int SMP_W   = 16;  // Q4.12 sample
  localparam int TIME_W  = 32;
  localparam int Q_W     = 16;  // Q8.8 result fields
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 9;   // columns_in_use / rows_in_use
  localparam int LIM_W   = 13;  // holds any count limit up to 4096
  localparam int REG_W   = 3;
  localparam int Q_BITS  = 17;  // quotient bits kept by the divider
  localparam int Q_CNT_W = 5;   // steps Q_BITS down to 0

  localparam logic [REG_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [REG_W-1:0] REG_SPACING_X  = 3'd1;
  localparam logic [REG_W-1:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [REG_W-1:0] REG_SPACING_Y  = 3'd3;
  localparam logic [REG_W-1:0] REG_HALF_SHIFT = 3'd4;
  localparam logic [REG_W-1:0] REG_COLUMNS    = 3'd5;
  localparam logic [REG_W-1:0] REG_ROWS       = 3'd6;

  localparam logic [CFG_W-1:0] SPACING_RST = 16'd256;
  localparam logic [CNT_W-1:0] COUNT_RST   = 9'd256;

  localparam logic [Q_BITS-1:0] POS_LIM = 17'd32767;
  localparam logic [Q_BITS-1:0] NEG_LIM = 17'd32768;
  localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [Q_W-1:0] Q_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [TIME_W-1:0]       frame_time;
  } gcv_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] centroid_x;
    logic signed [Q_W-1:0] centroid_y;
    logic signed [Q_W-1:0] velocity_x;
    logic signed [Q_W-1:0] velocity_y;
    logic                  empty_frame;
    logic                  zero_time_step;
  } gcv_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_XI,
    ST_MUL_YI,
    ST_MUL_SX,
    ST_MUL_SY,
    ST_ACC,
    ST_DCX_GO,
    ST_DCX_WAIT,
    ST_DCY_GO,
    ST_DCY_WAIT,
    ST_DVX_GO,
    ST_DVX_WAIT,
    ST_DVY_GO,
    ST_DVY_WAIT,
    ST_OUT
  } gcv_state_e;

  typedef enum logic [1:0] {
    MS_XI,
    MS_YI,
    MS_SX,
    MS_SY
  } gcv_msel_e;

  typedef enum logic [1:0] {
    DS_CX,
    DS_CY,
    DS_VX,
    DS_VY
  } gcv_dsel_e;

  typedef struct packed {
    logic      mul_en;
    gcv_msel_e mul_sel;
    logic      div_start;
    gcv_dsel_e div_sel;
  } gcv_ctl_t;

endpackage

### hdl/gcv_mul.sv
module gcv_mul #(
  parameter int A_W = 17,
  parameter int B_W = 27
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

### hdl/gcv_div.sv
module gcv_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 34
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [NUM_W-1:0]      num_i,
  input  logic signed [DEN_W-1:0]      den_i,
  output logic                         done_o,
  output logic signed [gcv_pkg::Q_W-1:0] quot_o
);

  localparam int RW   = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1;
  localparam int SH_W = DEN_W + 1 + gcv_pkg::Q_BITS;
  localparam int CW   = (RW > SH_W) ? RW : SH_W;

  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad;
  logic [CW-1:0]    rem_q, rem_d, dsh_q, dsh_d;
  logic [gcv_pkg::Q_BITS-1:0]  q_q, q_d;
  logic [gcv_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d, ovf_q, ovf_d, neg_q, neg_d;
  logic             ge;

  assign an = num_i[NUM_W-1] ? (~num_i) + NUM_W'(1) : num_i;
  assign ad = den_i[DEN_W-1] ? (~den_i) + DEN_W'(1) : den_i;
  assign ge = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      // numerator 2|n| + |d|, divisor 2|d|: rounds half away from zero
      rem_d  = (CW'(an) << 1) + CW'(ad);
      dsh_d  = CW'(ad) << (gcv_pkg::Q_BITS + 1);
      q_d    = '0;
      cnt_d  = gcv_pkg::Q_CNT_W'(gcv_pkg::Q_BITS);
      busy_d = 1'b1;
      ovf_d  = 1'b0;
      neg_d  = num_i[NUM_W-1] ^ den_i[DEN_W-1];
    end else if (busy_q) begin
      if (cnt_q == gcv_pkg::Q_CNT_W'(gcv_pkg::Q_BITS)) begin
        // quotient too large for the kept bits: saturate later
        ovf_d = ge;
      end else begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        q_d = {q_q[gcv_pkg::Q_BITS-2:0], ge};
      end
      dsh_d = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - gcv_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      if (ovf_q || q_q > gcv_pkg::NEG_LIM) begin
        quot_o = gcv_pkg::Q_MIN;
      end else begin
        quot_o = signed'(gcv_pkg::Q_W'((~q_q) + gcv_pkg::Q_BITS'(1)));
      end
    end else begin
      if (ovf_q || q_q > gcv_pkg::POS_LIM) begin
        quot_o = gcv_pkg::Q_MAX;
      end else begin
        quot_o = signed'(q_q[gcv_pkg::Q_W-1:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

### hdl/grid_centroid_velocity.sv
// Weighted centroid and centroid velocity of a sampled grid. Samples arrive
// column-major, one per beat; the block takes one sample, then works on it
// in one shared multiplier (x coordinate, y coordinate, sample times x,
// sample times y) and a final add before it takes the next sample.
// The last sample of a frame also runs up to four divisions through one
// shared restoring divider at one quotient bit per cycle, and a frame end
// may also wait for the previous result beat to leave the output register.
// in_ready_o is high only while the block is waiting for a sample.
// Configuration writes are taken at once and should be made while the
// block is idle.
module grid_centroid_velocity #(
  parameter int MAX_COLUMNS = gcv_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = gcv_pkg::MaxRowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gcv_pkg::REG_W-1:0] cfg_idx_i,
  input  logic [gcv_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gcv_pkg::gcv_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gcv_pkg::gcv_out_t         out_data_o
);

  localparam int IX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int IY_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI_W   = ((IX_W > IY_W) ? IX_W : IY_W) + 1;
  localparam int C_W    = CI_W + 18;
  localparam int A_W    = gcv_pkg::SMP_W + 1;
  localparam int P_W    = A_W + C_W;
  localparam int CB     = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
  localparam int TOT_W  = gcv_pkg::SMP_W + CB;
  localparam int WS_W   = gcv_pkg::SMP_W + C_W + CB;
  localparam int DT_W   = gcv_pkg::TIME_W + 1;
  localparam int DEN_W  = (TOT_W + 1 > DT_W) ? TOT_W + 1 : DT_W;
  localparam int Q_W    = gcv_pkg::Q_W;

  // configuration
  logic signed [gcv_pkg::CFG_W-1:0] origin_x_q, origin_y_q;
  logic [gcv_pkg::CFG_W-1:0]        spacing_x_q, spacing_y_q;
  logic                             half_q;
  logic [gcv_pkg::CNT_W-1:0]        columns_q, rows_q;

  gcv_pkg::gcv_state_e state_q, state_d;
  gcv_pkg::gcv_ctl_t   ctl;
  gcv_pkg::gcv_in_t    smp_q;
  gcv_pkg::gcv_out_t   out_q;
  logic                out_valid_q, out_valid_d, load_out;

  logic [IX_W-1:0]          col_q;
  logic [IY_W-1:0]          row_q;
  logic signed [TOT_W-1:0]  tot_q;
  logic signed [WS_W-1:0]   wx_q, wy_q;
  logic signed [C_W-1:0]    xc_q, yc_q;
  logic signed [Q_W-1:0]    cx_q, cy_q, vx_q, vy_q, pcx_q, pcy_q;
  logic [gcv_pkg::TIME_W-1:0] pft_q;
  logic                     empty_q, still_q;

  logic [gcv_pkg::LIM_W-1:0] cols_lim, rows_lim;
  logic                      last_row, last_col, frame_end, tot_zero, time_same;

  logic signed [A_W-1:0]   mul_a;
  logic signed [C_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [WS_W-1:0]  div_num;
  logic signed [DEN_W-1:0] div_den;
  logic signed [DT_W-1:0]  dt;
  logic signed [Q_W+1-1:0] dcx, dcy;
  logic                    div_done;
  logic signed [Q_W-1:0]   div_quot;

  // count limits: zero acts as one, large values clip to the maximum
  always_comb begin
    if (columns_q == '0) begin
      cols_lim = gcv_pkg::LIM_W'(1);
    end else if (gcv_pkg::LIM_W'(columns_q) > gcv_pkg::LIM_W'(MAX_COLUMNS)) begin
      cols_lim = gcv_pkg::LIM_W'(MAX_COLUMNS);
    end else begin
      cols_lim = gcv_pkg::LIM_W'(columns_q);
    end
    if (rows_q == '0) begin
      rows_lim = gcv_pkg::LIM_W'(1);
    end else if (gcv_pkg::LIM_W'(rows_q) > gcv_pkg::LIM_W'(MAX_ROWS)) begin
      rows_lim = gcv_pkg::LIM_W'(MAX_ROWS);
    end else begin
      rows_lim = gcv_pkg::LIM_W'(rows_q);
    end
  end

  assign last_row  = gcv_pkg::LIM_W'(row_q) + gcv_pkg::LIM_W'(1) >= rows_lim;
  assign last_col  = gcv_pkg::LIM_W'(col_q) + gcv_pkg::LIM_W'(1) >= cols_lim;
  assign frame_end = last_row && last_col;
  assign tot_zero  = tot_q == '0;
  assign time_same = smp_q.frame_time == pft_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcv_pkg::ST_IDLE:     if (in_valid_i) state_d = gcv_pkg::ST_MUL_XI;
      gcv_pkg::ST_MUL_XI:   state_d = gcv_pkg::ST_MUL_YI;
      gcv_pkg::ST_MUL_YI:   state_d = gcv_pkg::ST_MUL_SX;
      gcv_pkg::ST_MUL_SX:   state_d = gcv_pkg::ST_MUL_SY;
      gcv_pkg::ST_MUL_SY:   state_d = gcv_pkg::ST_ACC;
      gcv_pkg::ST_ACC: begin
        state_d = frame_end ? gcv_pkg::ST_DCX_GO : gcv_pkg::ST_IDLE;
      end
      gcv_pkg::ST_DCX_GO: begin
        state_d = tot_zero ? gcv_pkg::ST_DVX_GO : gcv_pkg::ST_DCX_WAIT;
      end
      gcv_pkg::ST_DCX_WAIT: if (div_done) state_d = gcv_pkg::ST_DCY_GO;
      gcv_pkg::ST_DCY_GO:   state_d = gcv_pkg::ST_DCY_WAIT;
      gcv_pkg::ST_DCY_WAIT: if (div_done) state_d = gcv_pkg::ST_DVX_GO;
      gcv_pkg::ST_DVX_GO: begin
        state_d = time_same ? gcv_pkg::ST_OUT : gcv_pkg::ST_DVX_WAIT;
      end
      gcv_pkg::ST_DVX_WAIT: if (div_done) state_d = gcv_pkg::ST_DVY_GO;
      gcv_pkg::ST_DVY_GO:   state_d = gcv_pkg::ST_DVY_WAIT;
      gcv_pkg::ST_DVY_WAIT: if (div_done) state_d = gcv_pkg::ST_OUT;
      gcv_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = gcv_pkg::ST_IDLE;
      end
      default:              state_d = gcv_pkg::ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    ctl.mul_en    = 1'b0;
    ctl.mul_sel   = gcv_pkg::MS_XI;
    ctl.div_start = 1'b0;
    ctl.div_sel   = gcv_pkg::DS_CX;
    case (state_q)
      gcv_pkg::ST_MUL_XI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = gcv_pkg::MS_XI;
      end
      gcv_pkg::ST_MUL_YI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = gcv_pkg::MS_YI;
      end
      gcv_pkg::ST_MUL_SX: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = gcv_pkg::MS_SX;
      end
      gcv_pkg::ST_MUL_SY: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = gcv_pkg::MS_SY;
      end
      gcv_pkg::ST_DCX_GO: begin
        ctl.div_start = !tot_zero;
        ctl.div_sel   = gcv_pkg::DS_CX;
      end
      gcv_pkg::ST_DCY_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = gcv_pkg::DS_CY;
      end
      gcv_pkg::ST_DVX_GO: begin
        ctl.div_start = !time_same;
        ctl.div_sel   = gcv_pkg::DS_VX;
      end
      gcv_pkg::ST_DVY_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = gcv_pkg::DS_VY;
      end
      default: begin
        ctl.mul_en = 1'b0;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (ctl.mul_sel)
      gcv_pkg::MS_XI: begin
        mul_a = signed'({1'b0, spacing_x_q});
        mul_b = signed'(C_W'({col_q, half_q}));
      end
      gcv_pkg::MS_YI: begin
        mul_a = signed'({1'b0, spacing_y_q});
        mul_b = signed'(C_W'({row_q, half_q}));
      end
      gcv_pkg::MS_SX: begin
        mul_a = A_W'(smp_q.sample);
        mul_b = xc_q;
      end
      gcv_pkg::MS_SY: begin
        mul_a = A_W'(smp_q.sample);
        mul_b = yc_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gcv_mul #(
    .A_W (A_W),
    .B_W (C_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (ctl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // shared divider operands
  assign dt  = signed'({1'b0, smp_q.frame_time}) - signed'({1'b0, pft_q});
  assign dcx = (Q_W + 1)'(cx_q) - (Q_W + 1)'(pcx_q);
  assign dcy = (Q_W + 1)'(cy_q) - (Q_W + 1)'(pcy_q);

  always_comb begin
    case (ctl.div_sel)
      gcv_pkg::DS_CX: begin
        div_num = wx_q;
        div_den = DEN_W'(tot_q) <<< 1;
      end
      gcv_pkg::DS_CY: begin
        div_num = wy_q;
        div_den = DEN_W'(tot_q) <<< 1;
      end
      gcv_pkg::DS_VX: begin
        div_num = WS_W'(dcx);
        div_den = DEN_W'(dt);
      end
      gcv_pkg::DS_VY: begin
        div_num = WS_W'(dcy);
        div_den = DEN_W'(dt);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gcv_div #(
    .NUM_W (WS_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign load_out    = (state_q == gcv_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcv_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      origin_x_q  <= '0;
      spacing_x_q <= gcv_pkg::SPACING_RST;
      origin_y_q  <= '0;
      spacing_y_q <= gcv_pkg::SPACING_RST;
      half_q      <= 1'b0;
      columns_q   <= gcv_pkg::COUNT_RST;
      rows_q      <= gcv_pkg::COUNT_RST;
      col_q       <= '0;
      row_q       <= '0;
      tot_q       <= '0;
      wx_q        <= '0;
      wy_q        <= '0;
      pcx_q       <= '0;
      pcy_q       <= '0;
      pft_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gcv_pkg::REG_ORIGIN_X:   origin_x_q  <= signed'(cfg_data_i);
          gcv_pkg::REG_SPACING_X:  spacing_x_q <= cfg_data_i;
          gcv_pkg::REG_ORIGIN_Y:   origin_y_q  <= signed'(cfg_data_i);
          gcv_pkg::REG_SPACING_Y:  spacing_y_q <= cfg_data_i;
          gcv_pkg::REG_HALF_SHIFT: half_q      <= cfg_data_i[0];
          gcv_pkg::REG_COLUMNS:    columns_q   <= cfg_data_i[gcv_pkg::CNT_W-1:0];
          gcv_pkg::REG_ROWS:       rows_q      <= cfg_data_i[gcv_pkg::CNT_W-1:0];
          default:                 half_q      <= half_q;
        endcase
      end
      if (state_q == gcv_pkg::ST_MUL_SY) begin
        wx_q <= wx_q + WS_W'(prod);
      end
      if (state_q == gcv_pkg::ST_ACC) begin
        wy_q  <= wy_q + WS_W'(prod);
        tot_q <= tot_q + TOT_W'(smp_q.sample);
        if (last_row) begin
          row_q <= '0;
          col_q <= last_col ? '0 : col_q + IX_W'(1);
        end else begin
          row_q <= row_q + IY_W'(1);
        end
      end
      if (load_out) begin
        // keep this frame as the reference and start the next one clean
        pcx_q <= cx_q;
        pcy_q <= cy_q;
        pft_q <= smp_q.frame_time;
        tot_q <= '0;
        wx_q  <= '0;
        wy_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= in_data_i;
    end
    // coordinates in 1/512 units: 2*origin + (2*index + shift)*spacing
    if (state_q == gcv_pkg::ST_MUL_YI) begin
      xc_q <= C_W'(prod) + (C_W'(origin_x_q) <<< 1);
    end
    if (state_q == gcv_pkg::ST_MUL_SX) begin
      yc_q <= C_W'(prod) + (C_W'(origin_y_q) <<< 1);
    end
    case (state_q)
      gcv_pkg::ST_DCX_GO: begin
        empty_q <= tot_zero;
        if (tot_zero) begin
          cx_q <= '0;
          cy_q <= '0;
        end
      end
      gcv_pkg::ST_DCX_WAIT: if (div_done) cx_q <= div_quot;
      gcv_pkg::ST_DCY_WAIT: if (div_done) cy_q <= div_quot;
      gcv_pkg::ST_DVX_GO: begin
        still_q <= time_same;
        if (time_same) begin
          vx_q <= '0;
          vy_q <= '0;
        end
      end
      gcv_pkg::ST_DVX_WAIT: if (div_done) vx_q <= div_quot;
      gcv_pkg::ST_DVY_WAIT: if (div_done) vy_q <= div_quot;
      default: begin
        empty_q <= empty_q;
      end
    endcase
    if (load_out) begin
      out_q.centroid_x     <= cx_q;
      out_q.centroid_y     <= cy_q;
      out_q.velocity_x     <= vx_q;
      out_q.velocity_y     <= vy_q;
      out_q.empty_frame    <= empty_q;
      out_q.zero_time_step <= still_q;
    end
  end

  assign in_ready_o  = state_q == gcv_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/gcv_checker.sv
module gcv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gcv_pkg::gcv_out_t out_data_o
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed before it was taken");

  // one sample at a time: busy right after a sample is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a sample beat");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_frame |->
      out_data_o.centroid_x == '0 && out_data_o.centroid_y == '0)
    else $error("empty frame with nonzero centroid");

  a_still_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_time_step |->
      out_data_o.velocity_x == '0 && out_data_o.velocity_y == '0)
    else $error("zero time step with nonzero velocity");

endmodule

bind grid_centroid_velocity gcv_checker u_gcv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
